### hw/rtl/hmu_pkg.sv
// Shared constants, register codes and control types of the Heisenberg
// Metropolis update block. No dependencies.
package hmu_pkg;

  localparam int SIDE_DEF      = 32;
  localparam int EXP_DEPTH_DEF = 256;

  localparam int SPIN_W     = 16;
  localparam int COORD_IN_W = 5;
  localparam int RND_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DELTA_W    = 32;
  localparam int MUL_W      = 19;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 56;
  localparam int SPLIT      = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXCHANGE  = 3'd0,
    CFG_VERTICAL  = 3'd1,
    CFG_PLANAR    = 3'd2,
    CFG_FIELD_X   = 3'd3,
    CFG_FIELD_Y   = 3'd4,
    CFG_FIELD_Z   = 3'd5,
    CFG_INV_TEMP  = 3'd6,
    CFG_ZERO_TEMP = 3'd7
  } cfg_idx_t;

  // one issue slot of the shared multiply-accumulate unit
  typedef struct packed {
    logic issue;
    logic load;
    logic shift;
  } mac_ctl_t;

endpackage

### hw/rtl/hmu_if.sv
// Valid/ready channel interfaces for trial/load items and results.
// Depends on hmu_pkg.
interface hmu_in_if;
  import hmu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [COORD_IN_W-1:0]    site_x;
  logic [COORD_IN_W-1:0]    site_y;
  logic [COORD_IN_W-1:0]    site_z;
  logic signed [SPIN_W-1:0] spin_x;
  logic signed [SPIN_W-1:0] spin_y;
  logic signed [SPIN_W-1:0] spin_z;
  logic [RND_W-1:0]         random_uniform;

  modport source(output valid, kind, site_x, site_y, site_z, spin_x, spin_y, spin_z,
                 random_uniform, input ready);
  modport sink(input valid, kind, site_x, site_y, site_z, spin_x, spin_y, spin_z,
               random_uniform, output ready);
endinterface

interface hmu_out_if;
  import hmu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic signed [DELTA_W-1:0] energy_change;
  logic signed [SPIN_W-1:0]  old_x;
  logic signed [SPIN_W-1:0]  old_y;
  logic signed [SPIN_W-1:0]  old_z;

  modport source(output valid, accepted, energy_change, old_x, old_y, old_z, input ready);
  modport sink(input valid, accepted, energy_change, old_x, old_y, old_z, output ready);
endinterface

### hw/rtl/hmu_spin_mem.sv
// Single-port spin lattice memory with registered read data.
// No package dependencies.
module hmu_spin_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/hmu_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate
// with optional shift of the product by SPLIT bits. Depends on hmu_pkg.
module hmu_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hmu_pkg::mac_ctl_t                ctl,
  input  logic signed [hmu_pkg::MUL_W-1:0] op_a,
  input  logic signed [hmu_pkg::MUL_W-1:0] op_b,
  input  logic signed [hmu_pkg::ACC_W-1:0] init,
  output logic signed [hmu_pkg::ACC_W-1:0] acc
);
  import hmu_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  init_r;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_nxt;

  assign prod_ext = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});

  always_comb begin
    acc_nxt = (ctl_r.load ? init_r : acc_r)
            + (ctl_r.shift ? (prod_ext <<< SPLIT) : prod_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    prod_r <= op_a * op_b;
    init_r <= init;
    if (ctl_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### hw/rtl/heisenberg_metropolis_update.sv
// Top level: sequencer, configuration registers, exp table, lattice memory
// and shared MAC. Depends on hmu_pkg, hmu_if, hmu_spin_mem and hmu_mac.
//
//   channel  | direction | handshake      | payload
//   in_ch    | in        | valid/ready    | kind, site_x/y/z, spin_x/y/z, random_uniform
//   out_ch   | out       | valid/ready    | accepted, energy_change, old_x/y/z
//   cfg_*    | in        | cfg_we only    | cfg_index, cfg_data
//
// A trial's length is set by the seven lattice reads from the single memory port and
// by up to 22 steps of the shared multiply-accumulate unit (18 for the energy change,
// 4 for the exp index). Reset (synchronous, rst_n low) restores the configuration
// and control registers; the lattice is not cleared.
// in_ch.ready is high only in idle; a result waits in the output register while
// the next item is accepted, and a stalled result holds the sequencer before idle.
module heisenberg_metropolis_update #(
  parameter int SIDE            = hmu_pkg::SIDE_DEF,
  parameter int EXP_TABLE_DEPTH = hmu_pkg::EXP_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hmu_in_if.sink                          in_ch,
  hmu_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hmu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hmu_pkg::CFG_W-1:0]       cfg_data
);
  import hmu_pkg::*;

  localparam int CW    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(EXP_TABLE_DEPTH);
  localparam int DW    = 3 * SPIN_W;

  typedef logic [16:0]   exp_tab_t [EXP_TABLE_DEPTH];
  typedef logic [CW-1:0] mod_tab_t [2**COORD_IN_W];

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_READ   = 10'b0000000010,
    S_MAC    = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_EXP    = 10'b0000010000,
    S_LOOK   = 10'b0000100000,
    S_CMP    = 10'b0001000000,
    S_WRITE  = 10'b0010000000,
    S_OUT    = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    NB_CENTER, NB_XP, NB_XM, NB_YP, NB_YM, NB_ZP, NB_ZM, NB_LAST
  } nb_t;

  typedef enum logic [2:0] {
    K_PLANAR, K_VERT, K_NSUM_LO, K_NSUM_HI, K_DOT_LO, K_DOT_HI
  } kstep_t;

  typedef enum logic [1:0] {
    E_ARG_LO, E_ARG_HI, E_IDX_LO, E_IDX_HI
  } estep_t;

  // shift-subtract quotient, evaluated only while building the exp table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic exp_tab_t exp_tab_build();
    exp_tab_t    t;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] p;
    longint      sum;
    sum  = longint'(1) <<< 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64(term * 64'd16, 64'(EXP_TABLE_DEPTH) * 64'(n));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = 64'(sum);
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    p = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) p = (p * r + 64'h8000_0000) >> 32;
      t[i] = 17'((p + 64'h8000) >> 16);
    end
    return t;
  endfunction

  function automatic mod_tab_t mod_tab_build();
    mod_tab_t t;
    int       v;
    for (int i = 0; i < 2**COORD_IN_W; i++) begin
      v = i;
      while (v >= SIDE) v = v - SIDE;
      t[i] = CW'(v);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_ROM = exp_tab_build();
  localparam mod_tab_t MOD_TAB = mod_tab_build();

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
    return (c == CW'(SIDE - 1)) ? '0 : CW'(c + 1'b1);
  endfunction

  function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] c);
    return (c == '0) ? CW'(SIDE - 1) : CW'(c - 1'b1);
  endfunction

  // configuration
  logic signed [15:0] j_r, vc_r, pc_r, hx_r, hy_r, hz_r;
  logic [15:0]        invt_r;
  logic               zt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r    <= 16'sd256;
      vc_r   <= 16'sd256;
      pc_r   <= 16'sd256;
      hx_r   <= '0;
      hy_r   <= '0;
      hz_r   <= '0;
      invt_r <= 16'd256;
      zt_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXCHANGE:  j_r    <= $signed(cfg_data);
        CFG_VERTICAL:  vc_r   <= $signed(cfg_data);
        CFG_PLANAR:    pc_r   <= $signed(cfg_data);
        CFG_FIELD_X:   hx_r   <= $signed(cfg_data);
        CFG_FIELD_Y:   hy_r   <= $signed(cfg_data);
        CFG_FIELD_Z:   hz_r   <= $signed(cfg_data);
        CFG_INV_TEMP:  invt_r <= cfg_data;
        CFG_ZERO_TEMP: zt_r   <= cfg_data[0];
      endcase
    end
  end

  // item and datapath registers
  state_t                    state_r;
  nb_t                       rd_cnt_r;
  kstep_t                    k_r;
  estep_t                    ek_r;
  logic [1:0]                comp_r;
  logic                      phase_r;
  logic                      kind_r;
  logic [CW-1:0]             cx_r, cy_r, cz_r;
  logic signed [SPIN_W-1:0]  nv_r [3];
  logic signed [SPIN_W-1:0]  old_r [3];
  logic signed [17:0]        planar_r [3];
  logic signed [16:0]        vert_r [3];
  logic [RND_W-1:0]          rnd_r;
  logic signed [15:0]        nsum_hi_r;
  logic signed [17:0]        coeff_hi_r;
  logic signed [ACC_W-1:0]   dot_r;
  logic [9:0]                arg_hi_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic                      flag_r;
  logic [16:0]               rom_r;

  logic                      out_valid_r;
  logic                      out_acc_r;
  logic signed [DELTA_W-1:0] out_delta_r;
  logic signed [SPIN_W-1:0]  out_old_r [3];

  // memory port
  nb_t                      nb_sel;
  nb_t                      nb_prev;
  logic [CW-1:0]            ax, ay, az;
  logic [AW-1:0]            mem_addr;
  logic                     mem_we;
  logic [DW-1:0]            mem_rdata;
  logic signed [SPIN_W-1:0] rd_spin [3];

  assign nb_sel  = (state_r == S_READ) ? rd_cnt_r : NB_CENTER;
  assign nb_prev = nb_t'(rd_cnt_r - 3'd1);

  always_comb begin
    ax = cx_r;
    ay = cy_r;
    az = cz_r;
    unique case (nb_sel)
      NB_XP:   ax = wrap_inc(cx_r);
      NB_XM:   ax = wrap_dec(cx_r);
      NB_YP:   ay = wrap_inc(cy_r);
      NB_YM:   ay = wrap_dec(cy_r);
      NB_ZP:   az = wrap_inc(cz_r);
      NB_ZM:   az = wrap_dec(cz_r);
      default: ;
    endcase
  end

  assign mem_addr = AW'((AW'(ax) * AW'(SIDE) + AW'(ay)) * AW'(SIDE) + AW'(az));
  assign mem_we   = (state_r == S_WRITE);
  assign rd_spin[0] = $signed(mem_rdata[47:32]);
  assign rd_spin[1] = $signed(mem_rdata[31:16]);
  assign rd_spin[2] = $signed(mem_rdata[15:0]);

  hmu_spin_mem #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({nv_r[0], nv_r[1], nv_r[2]}),
    .rdata (mem_rdata)
  );

  // component selection
  logic signed [17:0] planar_c;
  logic signed [16:0] vert_c;
  logic signed [15:0] h_c;
  logic signed [16:0] diff_c;

  always_comb begin
    unique case (comp_r)
      2'd0: begin
        planar_c = planar_r[0]; vert_c = vert_r[0]; h_c = hx_r;
        diff_c   = 17'(nv_r[0]) - 17'(old_r[0]);
      end
      2'd1: begin
        planar_c = planar_r[1]; vert_c = vert_r[1]; h_c = hy_r;
        diff_c   = 17'(nv_r[1]) - 17'(old_r[1]);
      end
      default: begin
        planar_c = planar_r[2]; vert_c = vert_r[2]; h_c = hz_r;
        diff_c   = 17'(nv_r[2]) - 17'(old_r[2]);
      end
    endcase
  end

  // shared MAC operands
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] mac_init;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    mac_init = '0;
    if (state_r == S_MAC && !phase_r) begin
      mac_ctl.issue = 1'b1;
      unique case (k_r)
        K_PLANAR: begin
          mac_a = MUL_W'(pc_r); mac_b = MUL_W'(planar_c); mac_ctl.load = 1'b1;
        end
        K_VERT: begin
          mac_a = MUL_W'(vc_r); mac_b = MUL_W'(vert_c);
        end
        K_NSUM_LO: begin
          mac_a = MUL_W'(j_r); mac_b = $signed({1'b0, acc[17:0]});
          mac_ctl.load = 1'b1;
          mac_init = $signed({{(ACC_W-38){h_c[15]}}, h_c, 22'd0});
        end
        K_NSUM_HI: begin
          mac_a = MUL_W'(j_r); mac_b = MUL_W'(nsum_hi_r); mac_ctl.shift = 1'b1;
        end
        K_DOT_LO: begin
          // acc holds J*sum + H, coefficient is that floored by 14 bits
          mac_a = $signed({1'b0, acc[31:14]}); mac_b = MUL_W'(diff_c);
          mac_ctl.load = 1'b1;
          mac_init = (comp_r == 2'd0) ? '0 : dot_r;
        end
        K_DOT_HI: begin
          mac_a = MUL_W'(coeff_hi_r); mac_b = MUL_W'(diff_c); mac_ctl.shift = 1'b1;
        end
        default: mac_ctl.issue = 1'b0;
      endcase
    end else if (state_r == S_EXP && !phase_r) begin
      mac_ctl.issue = 1'b1;
      unique case (ek_r)
        E_ARG_LO: begin
          mac_a = $signed({3'b0, invt_r}); mac_b = $signed({1'b0, delta_r[17:0]});
          mac_ctl.load = 1'b1;
        end
        E_ARG_HI: begin
          mac_a = $signed({3'b0, invt_r}); mac_b = $signed({9'b0, delta_r[27:18]});
          mac_ctl.shift = 1'b1;
        end
        E_IDX_LO: begin
          mac_a = $signed({1'b0, acc[17:0]}); mac_b = MUL_W'(EXP_TABLE_DEPTH);
          mac_ctl.load = 1'b1;
        end
        E_IDX_HI: begin
          mac_a = $signed({9'b0, arg_hi_r}); mac_b = MUL_W'(EXP_TABLE_DEPTH);
          mac_ctl.shift = 1'b1;
        end
      endcase
    end
  end

  hmu_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .init  (mac_init),
    .acc   (acc)
  );

  // energy change from the dot product: negate, floor by 14 bits, saturate
  logic signed [ACC_W-1:0]   neg_dot;
  logic signed [ACC_W-15:0]  dfull;
  logic signed [DELTA_W-1:0] delta_sat;
  logic                      arg_big;

  assign neg_dot = -acc;
  assign dfull   = neg_dot[ACC_W-1:14];
  assign arg_big = |acc[ACC_W-1:28];

  always_comb begin
    if (!dfull[ACC_W-15] && |dfull[ACC_W-16:31]) begin
      delta_sat = 32'sh7FFF_FFFF;
    end else if (dfull[ACC_W-15] && !(&dfull[ACC_W-16:31])) begin
      delta_sat = 32'sh8000_0000;
    end else begin
      delta_sat = dfull[31:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      // drop a taken result unless the output step reloads the register
      if (out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r   <= in_ch.kind;
            cx_r     <= MOD_TAB[in_ch.site_x];
            cy_r     <= MOD_TAB[in_ch.site_y];
            cz_r     <= MOD_TAB[in_ch.site_z];
            nv_r[0]  <= in_ch.spin_x;
            nv_r[1]  <= in_ch.spin_y;
            nv_r[2]  <= in_ch.spin_z;
            rnd_r    <= in_ch.random_uniform;
            delta_r  <= '0;
            rd_cnt_r <= NB_CENTER;
            for (int c = 0; c < 3; c++) begin
              planar_r[c] <= '0;
              vert_r[c]   <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (rd_cnt_r != NB_CENTER) begin
            for (int c = 0; c < 3; c++) begin
              unique case (nb_prev)
                NB_CENTER:                    old_r[c] <= rd_spin[c];
                NB_XP, NB_XM, NB_YP, NB_YM:   planar_r[c] <= planar_r[c] + 18'(rd_spin[c]);
                NB_ZP, NB_ZM:                 vert_r[c] <= vert_r[c] + 17'(rd_spin[c]);
                default: ;
              endcase
            end
          end
          if (!kind_r && rd_cnt_r == NB_XP) begin
            flag_r  <= 1'b1;
            state_r <= S_WRITE;
          end else if (rd_cnt_r == NB_LAST) begin
            comp_r  <= 2'd0;
            k_r     <= K_PLANAR;
            phase_r <= 1'b0;
            state_r <= S_MAC;
          end else begin
            rd_cnt_r <= nb_t'(rd_cnt_r + 3'd1);
          end
        end
        S_MAC: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            if (k_r == K_NSUM_LO) nsum_hi_r <= acc[33:18];
            if (k_r == K_DOT_LO)  coeff_hi_r <= acc[49:32];
            if (k_r == K_PLANAR && comp_r != 2'd0) dot_r <= acc;
          end else begin
            phase_r <= 1'b0;
            if (k_r == K_DOT_HI) begin
              k_r <= K_PLANAR;
              if (comp_r == 2'd2) state_r <= S_DECIDE;
              else                comp_r  <= comp_r + 2'd1;
            end else begin
              k_r <= kstep_t'(k_r + 3'd1);
            end
          end
        end
        S_DECIDE: begin
          delta_r <= delta_sat;
          priority if (delta_sat[DELTA_W-1]) begin
            flag_r  <= 1'b1;
            state_r <= S_WRITE;
          end else if (zt_r) begin
            flag_r  <= 1'b0;
            state_r <= S_OUT;
          end else if (|delta_sat[30:28]) begin
            // argument past the table unless the temperature scale is zero
            flag_r  <= (invt_r == '0);
            state_r <= (invt_r == '0) ? S_WRITE : S_OUT;
          end else begin
            ek_r    <= E_ARG_LO;
            phase_r <= 1'b0;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            if (ek_r == E_IDX_LO) begin
              arg_hi_r <= acc[27:18];
              if (arg_big) begin
                flag_r  <= 1'b0;
                state_r <= S_OUT;
              end
            end
          end else begin
            phase_r <= 1'b0;
            if (ek_r == E_IDX_HI) state_r <= S_LOOK;
            else                  ek_r    <= estep_t'(ek_r + 2'd1);
          end
        end
        S_LOOK: begin
          rom_r   <= EXP_ROM[acc[28 +: IW]];
          state_r <= S_CMP;
        end
        S_CMP: begin
          flag_r  <= ({1'b0, rnd_r} <= rom_r);
          state_r <= ({1'b0, rnd_r} <= rom_r) ? S_WRITE : S_OUT;
        end
        S_WRITE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_acc_r    <= flag_r;
            out_delta_r  <= delta_r;
            out_old_r[0] <= old_r[0];
            out_old_r[1] <= old_r[1];
            out_old_r[2] <= old_r[2];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.energy_change = out_delta_r;
  assign out_ch.old_x         = out_old_r[0];
  assign out_ch.old_y         = out_old_r[1];
  assign out_ch.old_z         = out_old_r[2];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again right after a transfer");

  a_write_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> flag_r)
    else $error("lattice written for a rejected trial");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

endmodule

### bench/tb_heisenberg_metropolis_update.sv
// Self-checking testbench for heisenberg_metropolis_update: loads and Metropolis
// trials against a lattice predictor. Depends on hmu_pkg, hmu_if and the RTL.
module tb_heisenberg_metropolis_update;
  import hmu_pkg::*;

  localparam int N   = SIDE_DEF;
  localparam int NS  = N * N * N;
  localparam int ED  = EXP_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bit                  kind;
    logic [4:0]          sx, sy, sz;
    logic signed [15:0]  vx, vy, vz;
    logic [15:0]         rnd;
  } lattice_op_t;

  typedef struct {
    bit                  accepted;
    logic signed [31:0]  energy_change;
    logic signed [15:0]  old_x, old_y, old_z;
  } update_result_t;

  class metropolis_scoreboard;
    shortint        spin_x[NS], spin_y[NS], spin_z[NS];
    bit             written[NS];
    longint unsigned boltz_rom[ED];
    longint         exch, vert, plan, inv_t;
    longint         field[3];
    bit             zero_t;
    update_result_t pending[$];
    int             errors, n_trials, n_accepts, n_results;

    function new();
      longint          s;
      longint unsigned term, r, p;
      s = 64'd1 << 32;
      term = 64'd1 << 32;
      p = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
        term = (term * 16) / (ED * n);
        if (n % 2) s -= longint'(term); else s += longint'(term);
      end
      if (s < 0) s = 0;
      r = s;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      for (int i = 0; i < ED; i++) begin
        if (i > 0) p = (p * r + 64'h8000_0000) >> 32;
        boltz_rom[i] = (p + 64'h8000) >> 16;
      end
      exch = 256; vert = 256; plan = 256;
      field = '{0, 0, 0};
      inv_t = 256; zero_t = 0;
    endfunction

    function int unsigned site(int x, int y, int z);
      return (((x % N) * N) + (y % N)) * N + (z % N);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_EXCHANGE:  exch = longint'($signed(v));
        CFG_VERTICAL:  vert = longint'($signed(v));
        CFG_PLANAR:    plan = longint'($signed(v));
        CFG_FIELD_X:   field[0] = longint'($signed(v));
        CFG_FIELD_Y:   field[1] = longint'($signed(v));
        CFG_FIELD_Z:   field[2] = longint'($signed(v));
        CFG_INV_TEMP:  inv_t = longint'(v);
        CFG_ZERO_TEMP: zero_t = v[0];
        default: ;
      endcase
    endfunction

    function longint comp(int unsigned a, int c);
      return (c == 0) ? spin_x[a] : (c == 1) ? spin_y[a] : spin_z[a];
    endfunction

    // work out the result of one accepted item and update the lattice
    function void note_input(lattice_op_t op);
      update_result_t  e;
      int              x, y, z;
      int unsigned     a;
      longint          nv[3], old[3], pl, vt, cf, dot, d;
      longint unsigned arg, idx;
      x = op.sx; y = op.sy; z = op.sz;
      a = site(x, y, z);
      nv[0] = op.vx; nv[1] = op.vy; nv[2] = op.vz;
      for (int c = 0; c < 3; c++) old[c] = comp(a, c);
      d = 0;
      e.accepted = 1;
      if (op.kind) begin
        dot = 0;
        for (int c = 0; c < 3; c++) begin
          pl = comp(site(x + 1, y, z), c) + comp(site(x + N - 1, y, z), c)
             + comp(site(x, y + 1, z), c) + comp(site(x, y + N - 1, z), c);
          vt = comp(site(x, y, z + 1), c) + comp(site(x, y, z + N - 1), c);
          cf = exch * (plan * pl + vert * vt) + (field[c] <<< 22);
          cf = cf >>> 14;
          dot += cf * (nv[c] - old[c]);
        end
        d = (-dot) >>> 14;
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        if (d < 0) e.accepted = 1;
        else if (zero_t) e.accepted = 0;
        else begin
          arg = longint'(inv_t) * d;
          idx = (arg * ED) >> 28;
          e.accepted = (idx < ED) && (longint'(op.rnd) <= boltz_rom[idx]);
        end
        n_trials++;
        if (e.accepted) n_accepts++;
      end
      if (e.accepted) begin
        spin_x[a] = op.vx; spin_y[a] = op.vy; spin_z[a] = op.vz;
        written[a] = 1;
      end
      e.energy_change = d[31:0];
      e.old_x = old[0][15:0]; e.old_y = old[1][15:0]; e.old_z = old[2][15:0];
      pending.push_back(e);
    endfunction

    function void check(update_result_t got);
      update_result_t e;
      n_results++;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.accepted !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, got.accepted); errors++;
      end
      if (got.energy_change !== e.energy_change) begin
        $error("energy_change: expected %0d, got %0d", e.energy_change, got.energy_change);
        errors++;
      end
      if (got.old_x !== e.old_x) begin
        $error("old_x: expected %0d, got %0d", e.old_x, got.old_x); errors++;
      end
      if (got.old_y !== e.old_y) begin
        $error("old_y: expected %0d, got %0d", e.old_y, got.old_y); errors++;
      end
      if (got.old_z !== e.old_z) begin
        $error("old_z: expected %0d, got %0d", e.old_z, got.old_z); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  hmu_in_if  in_ch();
  hmu_out_if out_ch();

  heisenberg_metropolis_update uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  metropolis_scoreboard sb = new();
  bit no_idle;
  int idle_cycles;
  int n_sent;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver stalls
  initial begin
    int n;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      out_ch.ready <= 1;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    update_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.accepted = out_ch.accepted;
      got.energy_change = out_ch.energy_change;
      got.old_x = out_ch.old_x;
      got.old_y = out_ch.old_y;
      got.old_z = out_ch.old_z;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(lattice_op_t op);
    int g;
    in_ch.valid <= 1;
    in_ch.kind <= op.kind;
    in_ch.site_x <= op.sx; in_ch.site_y <= op.sy; in_ch.site_z <= op.sz;
    in_ch.spin_x <= op.vx; in_ch.spin_y <= op.vy; in_ch.spin_z <= op.vz;
    in_ch.random_uniform <= op.rnd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op);
    n_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_spin();
    int r;
    r = $urandom_range(9);
    if (r == 0) return -16'sd16384;
    if (r == 1) return 16'sd16384;
    if (r == 2) return 0;
    return $signed(16'($urandom_range(32768))) - 16'sd16384;
  endfunction

  function automatic logic [15:0] rand_rnd();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  task automatic load(int x, int y, int z, logic signed [15:0] a, logic signed [15:0] b,
                      logic signed [15:0] c);
    lattice_op_t op;
    op.kind = 0; op.sx = 5'(x); op.sy = 5'(y); op.sz = 5'(z);
    op.vx = a; op.vy = b; op.vz = c; op.rnd = rand_rnd();
    send(op);
  endtask

  // trial at a site; first fill any of its seven cells never written
  task automatic trial(int x, int y, int z, logic signed [15:0] a, logic signed [15:0] b,
                       logic signed [15:0] c, logic [15:0] rnd);
    lattice_op_t op;
    int xs[7], ys[7], zs[7];
    xs = '{x, x + 1, x + N - 1, x, x, x, x};
    ys = '{y, y, y, y + 1, y + N - 1, y, y};
    zs = '{z, z, z, z, z, z + 1, z + N - 1};
    for (int k = 0; k < 7; k++)
      if (!sb.written[sb.site(xs[k], ys[k], zs[k])])
        load(xs[k] % N, ys[k] % N, zs[k] % N, rand_spin(), rand_spin(), rand_spin());
    op.kind = 1; op.sx = 5'(x); op.sy = 5'(y); op.sz = 5'(z);
    op.vx = a; op.vy = b; op.vz = c; op.rnd = rnd;
    send(op);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= v[i];
      sb.set_reg(cfg_idx_t'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] coord_pick();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 16'(N - 1);
    return 16'($urandom_range(N - 1));
  endfunction

  initial begin
    logic [15:0] regs[8];
    int x, y, z;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 0; in_ch.kind = 0;
    in_ch.site_x = '0; in_ch.site_y = '0; in_ch.site_z = '0;
    in_ch.spin_x = '0; in_ch.spin_y = '0; in_ch.spin_z = '0;
    in_ch.random_uniform = '0;
    rst_n = 0;
    no_idle = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: corners, extreme spins, both signs of delta
    load(0, 0, 0, 16'sd16384, -16'sd16384, 16'sd16384);
    load(N - 1, N - 1, N - 1, -16'sd16384, -16'sd16384, -16'sd16384);
    trial(0, 0, 0, -16'sd16384, 16'sd16384, -16'sd16384, 16'h0000);
    trial(N - 1, N - 1, N - 1, 16'sd16384, 16'sd16384, 16'sd16384, 16'hFFFF);
    trial(0, 0, 0, 16'sd16384, 0, 0, 16'hFFFF);
    trial(0, N - 1, 0, 0, 0, -16'sd16384, 16'h8000);
    drain();
    // zero temperature: only downhill moves
    regs = '{16'd256, 16'd256, 16'd256, 16'h7FFF, 16'h8000, 16'd0, 16'd256, 16'd1};
    write_regs(regs);
    trial(0, 0, 0, 16'sd16384, 16'sd16384, 0, 16'h0000);
    trial(0, 0, 0, -16'sd16384, -16'sd16384, 0, 16'h0000);
    drain();
    // infinite temperature: everything accepted
    regs = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd0};
    write_regs(regs);
    trial(N - 1, 0, N - 1, 16'sd16384, 0, 0, 16'hFFFF);
    trial(N - 1, 0, N - 1, -16'sd16384, 0, 0, 16'hFFFF);
    drain();
    // coldest finite temperature: exp index runs past the table
    regs = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0};
    write_regs(regs);
    trial(0, 0, N - 1, 16'sd16384, -16'sd16384, 16'sd16384, 16'h0000);
    trial(0, 0, N - 1, -16'sd16384, 16'sd16384, -16'sd16384, 16'h0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 8; i++) regs[i] = 16'($urandom_range(65535));
      case (ph)
        0: regs = '{16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0};
        1: regs[7] = 1;
        2: begin regs[6] = 0; regs[7] = 0; end
        3: begin regs[6] = 16'hFFFF; regs[7] = 0; end
        default: begin
          regs[0] = 16'($urandom_range(1023) - 512);
          regs[6] = 16'($urandom_range(600));
          regs[7] = 16'($urandom_range(3) == 0);
        end
      endcase
      write_regs(regs);
      no_idle = (ph == 6);
      // cluster trials in a small region so most hit already loaded cells
      x = coord_pick(); y = coord_pick(); z = coord_pick();
      for (int k = 0; k < 40; k++) begin
        if (ph == 5 && k == 20) drain();
        if ($urandom_range(9) < 2)
          load((x + $urandom_range(3)) % N, (y + $urandom_range(3)) % N,
               (z + $urandom_range(3)) % N, rand_spin(), rand_spin(), rand_spin());
        else
          trial((x + $urandom_range(3)) % N, (y + $urandom_range(3)) % N,
                (z + $urandom_range(3)) % N, rand_spin(), rand_spin(), rand_spin(),
                rand_rnd());
      end
      drain();
    end
    no_idle = 0;

    $display("Sent %0d items, %0d Metropolis trials (%0d accepted), %0d results checked",
             n_sent, sb.n_trials, sb.n_accepts, sb.n_results);
    $display("over %0d register settings including zero and infinite temperature", 12);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
